@@ hw/rtl/hpdd_pkg.sv @@
// ----------------------------------------------------------------------------
// hpdd_pkg
// Shared types and constants of the heading PID differential drive core.
// ----------------------------------------------------------------------------
package hpdd_pkg;

  localparam logic [1:0] FUNC_DRIVE = 2'd0;
  localparam logic [1:0] FUNC_HOLD  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_TPI   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_TPI  = 3'd4;

  localparam logic [15:0] TICKS_PER_INCH_RESET = 16'd256;

  localparam logic [19:0] TRIM_ABOVE  = 20'd1280;
  localparam logic [19:0] TRIM_AMOUNT = 20'd589;

  localparam logic signed [15:0] SPEED_MAX = 16'sd32767;
  localparam logic signed [15:0] SPEED_MIN = -16'sd32767;

  localparam logic signed [39:0] SUM_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] SUM_MIN = {1'b1, {39{1'b0}}};

  typedef struct packed {
    logic [1:0]         func;
    logic signed [23:0] target_heading;
    logic signed [23:0] heading_now;
    logic signed [15:0] base_speed;
    logic [19:0]        distance;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
  } item_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               done_res;
  } result_t;

endpackage

@@ hw/rtl/heading_pid_differential_drive_core.sv @@
// ----------------------------------------------------------------------------
// heading_pid_differential_drive_core
// Heading-hold PID steering with a distance stop for a differential drive.
// ----------------------------------------------------------------------------
// Channel   Signals                       Direction  Content
// item      item_valid/item_ready/item    in         one control tick
// res       res_valid/res_ready/res       out        drive commands, done flag
// cfg       cfg_we/cfg_index/cfg_data     in         gains and ticks per inch
//
// One transaction is taken per cycle while item_ready is high; results are registered.
// The PID state is updated in the cycle a transaction is accepted, so
// back-to-back ticks see each other's error. Multiplies, sums and clamps run in
// one pass between the input register and the result register.
// A waiting result holds the result register, and item_ready drops once both are full.
// Reset clears the PID state, both valid flags and the config registers to their defaults.
// ----------------------------------------------------------------------------
module heading_pid_differential_drive_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  hpdd_pkg::item_t                     item,
  output logic                                res_valid,
  input  logic                                res_ready,
  output hpdd_pkg::result_t                   res,
  input  logic                                cfg_we,
  input  logic [hpdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hpdd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic signed [31:0] prop_gain;
  logic signed [31:0] integ_gain;
  logic signed [31:0] deriv_gain;
  logic [15:0]        left_tpi;
  logic [15:0]        right_tpi;

  logic signed [24:0] last_error;
  logic signed [39:0] error_sum;

  logic v1;
  logic r1, out_free;
  logic accept;

  logic signed [24:0] e_now;
  logic signed [25:0] d_now;
  logic signed [40:0] sum_wide;
  logic signed [39:0] sum_next;
  logic [19:0]        dist_trim;
  logic [31:0]        left_mag;
  logic [31:0]        right_mag;
  logic [35:0]        left_lim;
  logic [35:0]        right_lim;
  logic               finish;
  logic               clear_req;

  logic signed [24:0] s1_e;
  logic signed [25:0] s1_d;
  logic signed [19:0] s1_sh;
  logic [19:0]        s1_sl;
  logic signed [15:0] s1_base;
  logic               s1_zero;
  logic               s1_done;

  logic signed [56:0] prod_e;
  logic signed [57:0] prod_d;
  logic signed [52:0] prod_il;
  logic signed [51:0] prod_ih;
  logic signed [58:0] lo_sum;
  logic signed [49:0] lo_floor;
  logic signed [63:0] corr;
  logic signed [63:0] left_sum;
  logic signed [63:0] right_sum;
  logic signed [15:0] left_clamp;
  logic signed [15:0] right_clamp;
  hpdd_pkg::result_t  res_next;

  assign out_free   = !res_valid || res_ready;
  assign r1         = !v1 || out_free;
  assign item_ready = r1;
  assign accept     = item_valid && r1;

  always_comb begin
    e_now     = 25'(item.target_heading) - 25'(item.heading_now);
    d_now     = 26'(e_now) - 26'(last_error);
    sum_wide  = 41'(error_sum) + 41'(e_now);
    if (sum_wide > 41'(hpdd_pkg::SUM_MAX)) begin
      sum_next = hpdd_pkg::SUM_MAX;
    end else if (sum_wide < 41'(hpdd_pkg::SUM_MIN)) begin
      sum_next = hpdd_pkg::SUM_MIN;
    end else begin
      sum_next = sum_wide[39:0];
    end
    if (item.distance > hpdd_pkg::TRIM_ABOVE) begin
      dist_trim = item.distance - hpdd_pkg::TRIM_AMOUNT;
    end else begin
      dist_trim = item.distance;
    end
    left_mag  = item.left_count[31] ? 32'(-item.left_count) : item.left_count;
    right_mag = item.right_count[31] ? 32'(-item.right_count) : item.right_count;
    left_lim  = 36'(left_tpi) * 36'(dist_trim);
    right_lim = 36'(right_tpi) * 36'(dist_trim);
    clear_req = !(item.func == hpdd_pkg::FUNC_DRIVE || item.func == hpdd_pkg::FUNC_HOLD);
    finish    = (item.func == hpdd_pkg::FUNC_DRIVE)
                && ({left_mag, 16'h0000} > 48'(left_lim))
                && ({right_mag, 16'h0000} > 48'(right_lim));
  end

  always_comb begin
    prod_e    = 57'(prop_gain) * 57'(s1_e);
    prod_d    = 58'(deriv_gain) * 58'(s1_d);
    prod_il   = 53'(integ_gain) * 53'($signed({1'b0, s1_sl}));
    prod_ih   = 52'(integ_gain) * 52'(s1_sh);
    lo_sum    = 59'(prod_e) + 59'(prod_d) + 59'(prod_il);
    lo_floor  = $signed(lo_sum[58:9]);
    corr      = (64'(prod_ih) <<< 11) + 64'(lo_floor);
    left_sum  = 64'(s1_base) + corr;
    right_sum = 64'(s1_base) - corr;
    if (left_sum > 64'(hpdd_pkg::SPEED_MAX)) begin
      left_clamp = hpdd_pkg::SPEED_MAX;
    end else if (left_sum < 64'(hpdd_pkg::SPEED_MIN)) begin
      left_clamp = hpdd_pkg::SPEED_MIN;
    end else begin
      left_clamp = left_sum[15:0];
    end
    if (right_sum > 64'(hpdd_pkg::SPEED_MAX)) begin
      right_clamp = hpdd_pkg::SPEED_MAX;
    end else if (right_sum < 64'(hpdd_pkg::SPEED_MIN)) begin
      right_clamp = hpdd_pkg::SPEED_MIN;
    end else begin
      right_clamp = right_sum[15:0];
    end
    res_next.done_res = s1_done;
    if (s1_zero) begin
      res_next.left_drive  = '0;
      res_next.right_drive = '0;
    end else begin
      res_next.left_drive  = 16'(-left_clamp);
      res_next.right_drive = right_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
      left_tpi   <= hpdd_pkg::TICKS_PER_INCH_RESET;
      right_tpi  <= hpdd_pkg::TICKS_PER_INCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpdd_pkg::REG_PROP_GAIN:  prop_gain  <= $signed(cfg_data);
        hpdd_pkg::REG_INTEG_GAIN: integ_gain <= $signed(cfg_data);
        hpdd_pkg::REG_DERIV_GAIN: deriv_gain <= $signed(cfg_data);
        hpdd_pkg::REG_LEFT_TPI:   left_tpi   <= cfg_data[15:0];
        hpdd_pkg::REG_RIGHT_TPI:  right_tpi  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum  <= '0;
      v1         <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (clear_req || finish) begin
          last_error <= '0;
          error_sum  <= '0;
        end else begin
          last_error <= e_now;
          error_sum  <= sum_next;
        end
      end
      if (r1) begin
        v1 <= item_valid;
      end
      if (out_free) begin
        res_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_e    <= e_now;
      s1_d    <= d_now;
      s1_sh   <= error_sum[39:20];
      s1_sl   <= error_sum[19:0];
      s1_base <= item.base_speed;
      s1_zero <= clear_req || finish;
      s1_done <= finish;
    end
    if (out_free && v1) begin
      res <= res_next;
    end
  end

endmodule

@@ hw/rtl/hpdd_checker.sv @@
// ----------------------------------------------------------------------------
// hpdd_checker
// Port-level checks of the heading PID differential drive core.
// ----------------------------------------------------------------------------
module hpdd_checker (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input hpdd_pkg::result_t res
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // A finished drive always stops both motors.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> res.left_drive == 16'sd0 && res.right_drive == 16'sd0)
    else $error("done with nonzero drive");

  // Commands are clamped to the symmetric range.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.left_drive != 16'h8000 && res.right_drive != 16'h8000)
    else $error("drive outside clamp range");

  // No result leaves the block right after reset.
  assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind heading_pid_differential_drive_core hpdd_checker u_hpdd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

@@ verif/tb_heading_pid_differential_drive_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heading_pid_differential_drive_core
// Self-checking bench for the heading PID differential drive core. A directed
// table covers the field extremes, every function code, trimmed and untrimmed
// distances and the stop condition. Random phases follow, each with its own
// gain and ticks-per-inch setting. They mix drive runs that close in on the
// stop distance, heading-hold runs, clears and raw noise.
// Results of checked directed rows are compared with the table's expected
// values; all others with a bit-exact model of the steering math in the bench.
// ----------------------------------------------------------------------------
module tb_heading_pid_differential_drive_core;

  localparam logic [1:0]         FUNC_SPARE     = 2'd3;
  localparam int                 NDIR           = 22;
  localparam int                 PIPE_SETTLE    = 8;
  localparam int                 HOLD_CYCLES    = 300;
  localparam int                 WATCHDOG_LIMIT = 2000;

  typedef struct {
    hpdd_pkg::item_t   it;
    bit                chk;
    hpdd_pkg::result_t want;
  } drive_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             item_valid = 1'b0;
  logic                             item_ready;
  hpdd_pkg::item_t                  tick = '0;
  logic                             res_valid;
  logic                             res_ready = 1'b0;
  hpdd_pkg::result_t                drive_out;
  logic                             cfg_we = 1'b0;
  logic [hpdd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [hpdd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  bit                tick_typed = 1'b0;
  hpdd_pkg::result_t tick_want = '0;
  bit                steady = 1'b0;
  bit                hold_req = 1'b0;
  int                err_count = 0;
  int                idle_cycles = 0;

  logic signed [31:0] gain_p, gain_i, gain_d;
  logic [15:0]        tpi_left, tpi_right;
  logic signed [24:0] prev_err;
  logic signed [39:0] err_acc;
  hpdd_pkg::result_t  expected_drives [$];

  drive_row_t directed [NDIR];

  heading_pid_differential_drive_core dut (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (tick),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (drive_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic logic [31:0] rand_gain(input int span);
    return 32'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic hpdd_pkg::item_t noise_tick();
    hpdd_pkg::item_t it;
    it.func           = 2'($urandom);
    it.target_heading = 24'($urandom);
    it.heading_now    = 24'($urandom);
    it.base_speed     = 16'($urandom);
    it.distance       = 20'($urandom);
    it.left_count     = 32'($urandom);
    it.right_count    = 32'($urandom);
    return it;
  endfunction

  function automatic drive_row_t row(input logic [1:0] f, input int tgt, input int now,
                                     input int base, input int travel, input int lc,
                                     input int rc, input bit chk, input int ld, input int rd,
                                     input bit dn);
    drive_row_t r;
    r.it.func                = f;
    r.it.target_heading      = 24'(tgt);
    r.it.heading_now         = 24'(now);
    r.it.base_speed          = 16'(base);
    r.it.distance            = 20'(travel);
    r.it.left_count          = 32'(lc);
    r.it.right_count         = 32'(rc);
    r.chk                    = chk;
    r.want.left_drive        = 16'(ld);
    r.want.right_drive       = 16'(rd);
    r.want.done_res          = dn;
    return r;
  endfunction

  // Steering math for one tick; updates the bench copy of the PID state.
  function automatic hpdd_pkg::result_t predict_drive(input hpdd_pkg::item_t it);
    hpdd_pkg::result_t  r;
    logic signed [24:0] err;
    logic signed [79:0] err_w, prev_w, acc_w, base_w, corr, lft, rgt, nsum;
    logic signed [63:0] lc, rc;
    logic [63:0]        lmag, rmag;
    logic [19:0]        dtrim;
    r = '0;
    if (it.func != hpdd_pkg::FUNC_DRIVE && it.func != hpdd_pkg::FUNC_HOLD) begin
      prev_err = '0;
      err_acc  = '0;
      return r;
    end
    err    = {it.target_heading[23], it.target_heading} - {it.heading_now[23], it.heading_now};
    err_w  = 80'(err);
    prev_w = 80'(prev_err);
    acc_w  = 80'(err_acc);
    base_w = 80'(it.base_speed);
    corr   = (80'(gain_p) * err_w + 80'(gain_i) * acc_w + 80'(gain_d) * (err_w - prev_w)) >>> 9;
    lft    = base_w + corr;
    rgt    = base_w - corr;
    if (lft > 80'(hpdd_pkg::SPEED_MAX)) lft = 80'(hpdd_pkg::SPEED_MAX);
    else if (lft < 80'(hpdd_pkg::SPEED_MIN)) lft = 80'(hpdd_pkg::SPEED_MIN);
    if (rgt > 80'(hpdd_pkg::SPEED_MAX)) rgt = 80'(hpdd_pkg::SPEED_MAX);
    else if (rgt < 80'(hpdd_pkg::SPEED_MIN)) rgt = 80'(hpdd_pkg::SPEED_MIN);
    if (it.func == hpdd_pkg::FUNC_DRIVE) begin
      dtrim = (it.distance > hpdd_pkg::TRIM_ABOVE) ? it.distance - hpdd_pkg::TRIM_AMOUNT
                                                   : it.distance;
      lc    = 64'(it.left_count);
      rc    = 64'(it.right_count);
      lmag  = (lc < 0) ? -lc : lc;
      rmag  = (rc < 0) ? -rc : rc;
      if ((lmag << 16) > 64'(tpi_left) * 64'(dtrim) &&
          (rmag << 16) > 64'(tpi_right) * 64'(dtrim)) begin
        prev_err   = '0;
        err_acc    = '0;
        r.done_res = 1'b1;
        return r;
      end
    end
    r.left_drive  = -lft[15:0];
    r.right_drive = rgt[15:0];
    prev_err      = err;
    nsum          = acc_w + err_w;
    if (nsum > 80'(hpdd_pkg::SUM_MAX)) nsum = 80'(hpdd_pkg::SUM_MAX);
    else if (nsum < 80'(hpdd_pkg::SUM_MIN)) nsum = 80'(hpdd_pkg::SUM_MIN);
    err_acc = nsum[39:0];
    return r;
  endfunction

  task automatic log_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : scoreboard
    hpdd_pkg::result_t want, got;
    if (rst) begin
      gain_p    = '0;
      gain_i    = '0;
      gain_d    = '0;
      tpi_left  = hpdd_pkg::TICKS_PER_INCH_RESET;
      tpi_right = hpdd_pkg::TICKS_PER_INCH_RESET;
      prev_err  = '0;
      err_acc   = '0;
    end else begin
      if (res_valid && res_ready) begin
        got = drive_out;
        if (expected_drives.size() == 0) begin
          log_error($sformatf("Unexpected result: left %0d right %0d done %0b",
                              got.left_drive, got.right_drive, got.done_res));
        end else begin
          want = expected_drives.pop_front();
          if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
              got.done_res !== want.done_res) begin
            log_error($sformatf({"Result mismatch: expected left %0d right %0d done %0b, ",
                                 "got left %0d right %0d done %0b"},
                                want.left_drive, want.right_drive, want.done_res,
                                got.left_drive, got.right_drive, got.done_res));
          end
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          hpdd_pkg::REG_PROP_GAIN:  gain_p = cfg_data;
          hpdd_pkg::REG_INTEG_GAIN: gain_i = cfg_data;
          hpdd_pkg::REG_DERIV_GAIN: gain_d = cfg_data;
          hpdd_pkg::REG_LEFT_TPI:   tpi_left = cfg_data[15:0];
          hpdd_pkg::REG_RIGHT_TPI:  tpi_right = cfg_data[15:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        want = predict_drive(tick);
        expected_drives.push_back(tick_typed ? tick_want : want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (res_valid && res_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : receiver
    int stall;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        stall = steady ? 0 : idle_len();
        if (stall == 0) begin
          res_ready <= 1'b1;
        end else begin
          res_ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic send_tick(input hpdd_pkg::item_t it, input bit chk,
                           input hpdd_pkg::result_t typed);
    int gap;
    gap = steady ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    tick       <= it;
    tick_typed <= chk;
    tick_want  <= typed;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] kp, input logic [31:0] ki,
                            input logic [31:0] kd, input logic [31:0] lt,
                            input logic [31:0] rt);
    logic [hpdd_pkg::CFG_INDEX_W-1:0] idx [5];
    logic [hpdd_pkg::CFG_DATA_W-1:0]  val [5];
    idx = '{hpdd_pkg::REG_PROP_GAIN, hpdd_pkg::REG_INTEG_GAIN, hpdd_pkg::REG_DERIV_GAIN,
            hpdd_pkg::REG_LEFT_TPI, hpdd_pkg::REG_RIGHT_TPI};
    val = '{kp, ki, kd, lt, rt};
    for (int k = 0; k < 5; k++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drive runs approach the stop distance with growing encoder counts; hold runs, clears and noise ticks are mixed in.
  task automatic run_random(input int count);
    hpdd_pkg::item_t it;
    int              sent, kind, len, travel, hd, base, step_l, step_r, sgn_l, sgn_r;
    logic [19:0]     dtrim;
    logic [63:0]     thr_l, thr_r;
    sent = 0;
    while (sent < count) begin
      kind = int'($urandom_range(0, 99));
      if (kind < 80) begin
        len    = int'($urandom_range(2, 14));
        hd     = int'($urandom_range(0, 92160)) - 46080;
        base   = int'($urandom_range(0, 40000)) - 20000;
        travel = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 1048575))
                                              : int'($urandom_range(0, 6000));
        dtrim  = (20'(travel) > hpdd_pkg::TRIM_ABOVE) ? 20'(travel) - hpdd_pkg::TRIM_AMOUNT
                                                      : 20'(travel);
        thr_l  = (64'(tpi_left) * 64'(dtrim)) >> 16;
        thr_r  = (64'(tpi_right) * 64'(dtrim)) >> 16;
        step_l = int'(thr_l / 64'(len)) + 1;
        step_r = int'(thr_r / 64'(len)) + 1;
        sgn_l  = $urandom_range(0, 1) ? 1 : -1;
        sgn_r  = $urandom_range(0, 1) ? 1 : -1;
        for (int k = 0; k <= len; k++) begin
          it                = noise_tick();
          it.func           = (kind < 55) ? hpdd_pkg::FUNC_DRIVE : hpdd_pkg::FUNC_HOLD;
          it.target_heading = 24'(hd);
          it.heading_now    = 24'(hd + int'($urandom_range(0, 6000)) - 3000);
          it.base_speed     = 16'(base);
          if (kind < 55) begin
            it.distance    = 20'(travel);
            it.left_count  = 32'(sgn_l * k * step_l);
            it.right_count = 32'(sgn_r * k * step_r);
          end
          send_tick(it, 1'b0, '0);
          sent++;
        end
      end else begin
        it = noise_tick();
        if (kind < 88) it.func = $urandom_range(0, 1) ? hpdd_pkg::FUNC_CLEAR : FUNC_SPARE;
        send_tick(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin : main
    directed = '{
      row(hpdd_pkg::FUNC_HOLD, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0),
      row(hpdd_pkg::FUNC_HOLD, 8388607, -8388608, 32767, 0, 0, 0, 1, -32767, 32767, 0),
      row(hpdd_pkg::FUNC_HOLD, -8388608, 8388607, -32768, 0, 0, 0, 1, 32767, -32767, 0),
      row(hpdd_pkg::FUNC_HOLD, 0, 0, -32767, 0, 0, 0, 1, 32767, -32767, 0),
      row(hpdd_pkg::FUNC_HOLD, 1000, 1000, 1234, 1048575, 32'h8000_0000, 32'h7fff_ffff,
          1, -1234, 1234, 0),
      row(hpdd_pkg::FUNC_DRIVE, 0, 0, 1000, 0, 0, 0, 1, -1000, 1000, 0),
      row(hpdd_pkg::FUNC_DRIVE, 0, 0, 1000, 0, 1, -1, 1, 0, 0, 1),
      row(hpdd_pkg::FUNC_DRIVE, 0, 0, 500, 0, 1, 0, 1, -500, 500, 0),
      row(hpdd_pkg::FUNC_DRIVE, 0, 0, -200, 1280, 5, 5, 1, 200, -200, 0),
      row(hpdd_pkg::FUNC_DRIVE, 0, 0, -200, 1280, 6, -6, 1, 0, 0, 1),
      row(hpdd_pkg::FUNC_DRIVE, 0, 0, 300, 1281, 3, 3, 1, 0, 0, 1),
      row(hpdd_pkg::FUNC_DRIVE, 0, 0, 0, 1281, -2, 3, 1, 0, 0, 0),
      row(hpdd_pkg::FUNC_DRIVE, 0, 0, 5, 1048575, 32'h7fff_ffff, 32'h8000_0000,
          1, 0, 0, 1),
      row(hpdd_pkg::FUNC_DRIVE, 0, 0, 32767, 1048575, 4093, 4094, 1, -32767, 32767, 0),
      row(hpdd_pkg::FUNC_DRIVE, 0, 0, 32767, 1048575, 4094, 4094, 1, 0, 0, 1),
      row(hpdd_pkg::FUNC_CLEAR, 12345, -999, 7777, 77, 1, 1, 1, 0, 0, 0),
      row(FUNC_SPARE, -1, 1, -1, 1048575, -1, -1, 1, 0, 0, 0),
      row(hpdd_pkg::FUNC_HOLD, -1, 1, -32768, 1048575, 0, 0, 1, 32767, -32767, 0),
      row(hpdd_pkg::FUNC_DRIVE, -1, -1, -1, 1048575, -1, -1, 1, 1, -1, 0),
      row(hpdd_pkg::FUNC_DRIVE, 46080, -46080, 16384, 2560, 10, -10, 0, 0, 0, 0),
      row(hpdd_pkg::FUNC_HOLD, 3000, 2500, -16384, 0, 0, 0, 0, 0, 0, 0),
      row(hpdd_pkg::FUNC_DRIVE, -700, 700, 9000, 1281, -3, 2, 0, 0, 0, 0)
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[k]) send_tick(directed[k].it, directed[k].chk, directed[k].want);
    drain();

    write_regs(rand_gain(3000), rand_gain(150), rand_gain(3000), 32'd256, 32'd256);
    run_random(100);
    drain();

    steady = 1'b1;
    write_regs(rand_gain(3000), rand_gain(150), rand_gain(3000),
               32'($urandom_range(128, 1024)), 32'($urandom_range(128, 1024)));
    run_random(50);
    drain();

    steady = 1'b0;
    write_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_ffff);
    run_random(40);
    drain();

    write_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    run_random(40);
    drain();

    write_regs($urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(60);
    drain();

    // The receiver holds off while the sender keeps offering, so the core backs up.
    write_regs(rand_gain(3000), rand_gain(150), rand_gain(3000), 32'd256, 32'd300);
    hold_req = 1'b1;
    steady   = 1'b1;
    run_random(60);
    drain();

    steady = 1'b0;
    write_regs(rand_gain(3000), rand_gain(150), rand_gain(3000), 32'd1, 32'd65535);
    run_random(60);
    drain();

    write_regs(32'd0, 32'd0, 32'd0, 32'd256, 32'd256);
    run_random(40);
    drain();

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/hpdd_pkg.sv
hw/rtl/heading_pid_differential_drive_core.sv
hw/rtl/hpdd_checker.sv
verif/tb_heading_pid_differential_drive_core.sv
